FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/hgbb_pkg.sv
// Shared constants, payload types and controller interface types for the box blur unit.
package hgbb_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_ROWS   = 256;
   localparam int MAX_RADIUS = 8;

   localparam int COL_W      = 8;
   localparam int ROW_W      = 8;
   localparam int SAMPLE_W   = 16;
   localparam int DIM_W      = 9;
   localparam int RAD_W      = 4;
   localparam int CNT_W      = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam int DEPTH     = MAX_WIDTH * MAX_ROWS;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int SPAN_W    = (MAX_RADIUS > 1) ? $clog2(2 * MAX_RADIUS) : 1;
   localparam int POS_W     = DIM_W + 1;
   localparam int SUM_W     = SAMPLE_W + $clog2(4 * MAX_RADIUS * MAX_RADIUS);
   localparam int DIV_CNT_W = $clog2(SUM_W);

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_RADIUS = 2'd2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef struct packed {
      logic                       operation;
      logic [COL_W-1:0]           col;
      logic [ROW_W-1:0]           row;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filtered;
      logic [CNT_W-1:0]           cells_counted;
      logic                       status;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic mem_write;
      logic walk_step;
      logic div_load;
      logic div_step;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic coord_bad;
      logic is_read;
      logic walk_last;
      logic div_last;
      logic rsp_free;
   } sts_type;

endpackage

FILE: rtl/height_grid_box_blur_unit.sv
// Read request: after acceptance the unit decodes, steps through every window cell, drains,
// loads and runs the divider and loads the response; the next request is taken the cycle
// after that load. Write request: the memory is written in the decode state and the unit
// returns to idle. Out-of-grid request: decode goes straight to the response load. A wait
// on the response holds the unit before that load and so delays the next request too.
// Synchronous reset restores the register defaults and empties the response, not the memory.
module height_grid_box_blur_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  hgbb_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output hgbb_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [hgbb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hgbb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hgbb_pkg::*;

   cmd_type cmd;
   sts_type sts;

   hgbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hgbb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

FILE: rtl/hgbb_ctrl.sv
// Controller state machine that sequences request capture, memory write, window walk, divide and response.
module hgbb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hgbb_pkg::sts_type sts,
   output hgbb_pkg::cmd_type cmd
);
   import hgbb_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_WALK     = 3'd2;
   localparam logic [2:0] S_DRAIN    = 3'd3;
   localparam logic [2:0] S_DIV_LOAD = 3'd4;
   localparam logic [2:0] S_DIV      = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.coord_bad) begin
               state_in = S_FINISH;
            end else if (sts.is_read) begin
               state_in = S_WALK;
            end else begin
               cmd.mem_write = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (sts.walk_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DIV_LOAD;
         end
         S_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/hgbb_datapath.sv
// Datapath with the height memory, window walker, accumulator, serial divider and response register.
module hgbb_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  hgbb_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output hgbb_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [hgbb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [hgbb_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  hgbb_pkg::cmd_type                     cmd,
   output hgbb_pkg::sts_type                     sts
);
   import hgbb_pkg::*;

   logic [SAMPLE_W-1:0] mem [0:DEPTH-1];

   logic [DIM_W-1:0]      grid_width_ff;
   logic [DIM_W-1:0]      grid_height_ff;
   logic [RAD_W-1:0]      radius_ff;
   req_type               req_ff;
   logic [SPAN_W-1:0]     dx_ff, dx_in;
   logic [SPAN_W-1:0]     dy_ff, dy_in;
   logic                  take_ff;
   logic [SAMPLE_W-1:0]   rd_data_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SUM_W-1:0]      quot_ff, quot_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic                  neg_ff;
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;

   logic [SPAN_W-1:0]       span_last;
   logic signed [POS_W-1:0] cx, cy;
   logic                    cx_in, cy_in;
   logic [ADDR_W-1:0]       rd_addr, wr_addr;
   logic [CNT_W:0]          rem_shift;
   logic [CNT_W+1:0]        trial;
   logic                    ge;
   logic [SAMPLE_W-1:0]     mag;
   logic signed [SAMPLE_W-1:0] mean;
   rsp_type                 rsp_next;

   // Register writes saturate into the legal range.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= DIM_W'(MAX_WIDTH);
         grid_height_ff <= DIM_W'(MAX_ROWS);
         radius_ff      <= RAD_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GRID_WIDTH: begin
               if (csr_wdata == '0) grid_width_ff <= DIM_W'(1);
               else if (int'(csr_wdata) > MAX_WIDTH) grid_width_ff <= DIM_W'(MAX_WIDTH);
               else grid_width_ff <= csr_wdata[DIM_W-1:0];
            end
            CSR_GRID_HEIGHT: begin
               if (csr_wdata == '0) grid_height_ff <= DIM_W'(1);
               else if (int'(csr_wdata) > MAX_ROWS) grid_height_ff <= DIM_W'(MAX_ROWS);
               else grid_height_ff <= csr_wdata[DIM_W-1:0];
            end
            CSR_WINDOW_RADIUS: begin
               if (csr_wdata[RAD_W-1:0] == '0) radius_ff <= RAD_W'(1);
               else if (int'(csr_wdata[RAD_W-1:0]) > MAX_RADIUS) radius_ff <= RAD_W'(MAX_RADIUS);
               else radius_ff <= csr_wdata[RAD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   assign sts.coord_bad = ({1'b0, req_ff.col} >= grid_width_ff) ||
                          ({1'b0, req_ff.row} >= grid_height_ff);
   assign sts.is_read   = (req_ff.operation == OP_READ);

   // Window walk: the window reaches radius cells back and radius minus one forward.
   assign span_last = SPAN_W'({radius_ff, 1'b0} - (RAD_W + 1)'(1));
   assign sts.walk_last = (dx_ff == span_last) && (dy_ff == span_last);

   assign cx = $signed(POS_W'(req_ff.col)) - $signed(POS_W'(radius_ff)) + $signed(POS_W'(dx_ff));
   assign cy = $signed(POS_W'(req_ff.row)) - $signed(POS_W'(radius_ff)) + $signed(POS_W'(dy_ff));
   assign cx_in = !cx[POS_W-1] && (cx[DIM_W-1:0] < grid_width_ff);
   assign cy_in = !cy[POS_W-1] && (cy[DIM_W-1:0] < grid_height_ff);

   assign rd_addr = ADDR_W'(cy[DIM_W-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cx[DIM_W-1:0]);
   assign wr_addr = ADDR_W'(req_ff.row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(req_ff.col);

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         mem[wr_addr] <= req_ff.sample;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      dx_in = dx_ff;
      dy_in = dy_ff;
      if (cmd.capture) begin
         dx_in = '0;
         dy_in = '0;
      end else if (cmd.walk_step) begin
         if (dx_ff == span_last) begin
            dx_in = '0;
            dy_in = dy_ff + SPAN_W'(1);
         end else begin
            dx_in = dx_ff + SPAN_W'(1);
         end
      end
   end

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (cmd.capture) begin
         sum_in   = '0;
         count_in = '0;
      end else if (take_ff) begin
         sum_in   = sum_ff + SUM_W'($signed(rd_data_ff));
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         take_ff <= 1'b0;
      end else begin
         take_ff <= cmd.walk_step && cx_in && cy_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      sum_ff   <= sum_in;
      count_ff <= count_in;
   end

   // Restoring divider on the magnitude of the sum, one quotient bit per cycle.
   assign rem_shift = {rem_ff, quot_ff[SUM_W-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, count_ff};
   assign ge        = !trial[CNT_W+1];

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (cmd.div_load) begin
         quot_in = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
         rem_in  = '0;
      end else if (cmd.div_step) begin
         quot_in = {quot_ff[SUM_W-2:0], ge};
         rem_in  = ge ? trial[CNT_W-1:0] : rem_shift[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (cmd.div_load) begin
         neg_ff     <= sum_ff[SUM_W-1];
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   assign sts.div_last = (div_cnt_ff == DIV_CNT_W'(SUM_W - 1));

   assign mag  = quot_ff[SAMPLE_W-1:0];
   assign mean = neg_ff ? $signed(-mag) : $signed(mag);

   always_comb begin
      if (sts.coord_bad) begin
         rsp_next.filtered      = '0;
         rsp_next.cells_counted = '0;
         rsp_next.status        = STATUS_RANGE;
      end else begin
         rsp_next.filtered      = mean;
         rsp_next.cells_counted = count_ff;
         rsp_next.status        = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

endmodule

FILE: rtl/hgbb_checker.sv
// Port-level checker for the box blur unit and its bind to the top level.
`include "assert_macros.svh"

module hgbb_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input hgbb_pkg::rsp_type rsp_data
);
   import hgbb_pkg::*;

   logic rsp_stall;
   logic rsp_range;
   logic rsp_good;
   logic rsp_cleared;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_range   = rsp_valid && (rsp_data.status == STATUS_RANGE);
   assign rsp_good    = rsp_valid && (rsp_data.status == STATUS_OK);
   assign rsp_cleared = (rsp_data.filtered == '0) && (rsp_data.cells_counted == '0);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_IMPLIES(a_error_zero, clock, reset, rsp_range, rsp_cleared)
   `ASSERT_IMPLIES(a_ok_counted, clock, reset, rsp_good, rsp_data.cells_counted != '0)

endmodule

bind height_grid_box_blur_unit hgbb_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: tb/height_grid_box_blur_unit_tb.sv
// Self-checking testbench for the height grid box blur unit with a built-in window-mean predictor.
`timescale 1ns / 1ps

module height_grid_box_blur_unit_tb;
   import hgbb_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int RESET_WIDTH   = 256;
   localparam int RESET_HEIGHT  = 256;
   localparam int RESET_RADIUS  = 1;
   localparam int SETTLE_CYCLES = 320;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_ITEMS   = 25;
   localparam int REPORT_LIMIT  = 10;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_kind_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic signed [SAMPLE_W-1:0] height_mem [DEPTH];
   bit                         cell_written [DEPTH];
   int                         grid_width_q;
   int                         grid_height_q;
   int                         radius_q;
   rsp_type                    expected_results [$];

   int             burst_left    = 0;
   int             stall_phase   = 0;
   stall_kind_type stall_mode    = STALL_NONE;
   logic [7:0]     stall_mask    = 8'hFF;
   int             read_count    = 0;
   int             write_count   = 0;
   int             range_count   = 0;
   int             setting_count = 1;
   int             checked_count = 0;
   int             failure_count = 0;

   height_grid_box_blur_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (stall_phase % 192 == 0) begin
         stall_mode = stall_kind_type'($urandom_range(0, 2));
         stall_mask = 8'($urandom_range(1, 255));
      end
      case (stall_mode)
         STALL_NONE: rsp_ready <= 1'b1;
         STALL_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= stall_mask[stall_phase % 8];
      endcase
      stall_phase++;
   end

   function automatic void report_failure(input string what, input rsp_type want,
                                          input rsp_type got);
      failure_count++;
      if (failure_count <= REPORT_LIMIT) begin
         $write("%0t %s: expected filtered %0d count %0d status %0d", $time, what,
                want.filtered, want.cells_counted, want.status);
         $display(", got filtered %0d count %0d status %0d",
                  got.filtered, got.cells_counted, got.status);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_failure("response with no request outstanding", '0, rsp_data);
         end else begin
            want = expected_results.pop_front();
            checked_count++;
            if (rsp_data.filtered !== want.filtered ||
                rsp_data.cells_counted !== want.cells_counted ||
                rsp_data.status !== want.status) begin
               report_failure("response mismatch", want, rsp_data);
            end
         end
      end
   end

   function automatic int clamp_setting(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_GRID_WIDTH: grid_width_q = clamp_setting(int'(value), 1, MAX_WIDTH);
         CSR_GRID_HEIGHT: grid_height_q = clamp_setting(int'(value), 1, MAX_ROWS);
         CSR_WINDOW_RADIUS: radius_q = clamp_setting(int'(value[RAD_W-1:0]), 1, MAX_RADIUS);
         default: ;
      endcase
   endfunction

   function automatic bit in_grid(input int col, input int row);
      return col < grid_width_q && row < grid_height_q;
   endfunction

   // Updates the shadow height store and returns 1 when the request yields a response.
   function automatic bit predict_response(input req_type item, output rsp_type rsp);
      longint sum;
      longint mean;
      int     count;
      int     base_col;
      int     base_row;
      rsp = '0;
      base_col = int'(item.col);
      base_row = int'(item.row);
      if (!in_grid(base_col, base_row)) begin
         rsp.status = STATUS_RANGE;
         range_count++;
         return 1'b1;
      end
      if (item.operation == OP_WRITE) begin
         height_mem[base_row * MAX_WIDTH + base_col] = item.sample;
         cell_written[base_row * MAX_WIDTH + base_col] = 1'b1;
         return 1'b0;
      end
      sum = 0;
      count = 0;
      for (int cy = base_row - radius_q; cy < base_row + radius_q; cy++) begin
         if (cy < 0 || cy >= grid_height_q) continue;
         for (int cx = base_col - radius_q; cx < base_col + radius_q; cx++) begin
            if (cx < 0 || cx >= grid_width_q) continue;
            sum += height_mem[cy * MAX_WIDTH + cx];
            count++;
         end
      end
      mean = sum / count;
      rsp.filtered = mean[SAMPLE_W-1:0];
      rsp.cells_counted = count[CNT_W-1:0];
      rsp.status = STATUS_OK;
      return 1'b1;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2, 3: return SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic void pick_spot(output int col, output int row);
      int dc;
      int dr;
      dc = $urandom_range(0, 3);
      dr = $urandom_range(0, 3);
      case ($urandom_range(0, 2))
         0: begin
            col = dc;
            row = dr;
         end
         1: begin
            col = MAX_WIDTH - 1 - dc;
            row = MAX_ROWS - 1 - dr;
         end
         default: begin
            col = 128 + dc;
            row = 64 + dr;
         end
      endcase
   endfunction

   task automatic send_request(input logic op, input int col, input int row,
                               input logic signed [SAMPLE_W-1:0] sample);
      req_type item;
      rsp_type outcome;
      bit      has_result;
      int      gap;
      item.operation = op;
      item.col = col[COL_W-1:0];
      item.row = row[ROW_W-1:0];
      item.sample = sample;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      has_result = predict_response(item, outcome);
      if (has_result) expected_results.push_back(outcome);
      if (op == OP_READ) read_count++;
      else write_count++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 48 : $urandom_range(0, 10);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic settle_block();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      apply_register(idx, value);
      @(posedge clock);
   endtask

   task automatic configure(input int width, input int height, input int radius);
      settle_block();
      write_register(CSR_GRID_WIDTH, CSR_DATA_W'(width));
      write_register(CSR_GRID_HEIGHT, CSR_DATA_W'(height));
      write_register(CSR_WINDOW_RADIUS, CSR_DATA_W'(radius));
      setting_count++;
   endtask

   // Writes the in-grid cells of a read window: all of them when flooding, else only unwritten ones.
   task automatic cover_window(input int col, input int row, input bit flood,
                               input logic signed [SAMPLE_W-1:0] value);
      for (int cy = row - radius_q; cy < row + radius_q; cy++) begin
         for (int cx = col - radius_q; cx < col + radius_q; cx++) begin
            if (cy >= 0 && cx >= 0 && in_grid(cx, cy)) begin
               if (flood) send_request(OP_WRITE, cx, cy, value);
               else if (!cell_written[cy * MAX_WIDTH + cx])
                  send_request(OP_WRITE, cx, cy, pick_sample());
            end
         end
      end
   endtask

   task automatic read_at(input int col, input int row);
      if (in_grid(col, row)) begin
         if ($urandom_range(0, 199) == 0) cover_window(col, row, 1'b1, pick_sample());
         cover_window(col, row, 1'b0, '0);
      end
      send_request(OP_READ, col, row, pick_sample());
   endtask

   task automatic random_item();
      int col;
      int row;
      int choice;
      pick_spot(col, row);
      choice = $urandom_range(0, 99);
      if (choice < 45) begin
         read_at(col, row);
      end else if (choice < 72) begin
         send_request(OP_WRITE, col, row, pick_sample());
      end else if (choice < 87) begin
         send_request(OP_WRITE, $urandom_range(0, MAX_WIDTH - 1),
                      $urandom_range(0, MAX_ROWS - 1), pick_sample());
      end else if (choice < 98) begin
         if (grid_width_q < MAX_WIDTH)
            send_request(OP_READ, $urandom_range(grid_width_q, MAX_WIDTH - 1),
                         $urandom_range(0, MAX_ROWS - 1), pick_sample());
         else if (grid_height_q < MAX_ROWS)
            send_request(OP_READ, $urandom_range(0, MAX_WIDTH - 1),
                         $urandom_range(grid_height_q, MAX_ROWS - 1), pick_sample());
         else
            read_at(col, row);
      end else begin
         drain_results();
      end
   endtask

   task automatic test_power_on_defaults();
      send_request(OP_WRITE, 0, 0, 16'sh0123);
      send_request(OP_READ, 0, 0, '0);
      cover_window(MAX_WIDTH - 1, MAX_ROWS - 1, 1'b0, '0);
      send_request(OP_READ, MAX_WIDTH - 1, MAX_ROWS - 1, '0);
   endtask

   task automatic test_mean_arithmetic();
      cover_window(11, 11, 1'b1, 16'shFFFF);
      send_request(OP_WRITE, 11, 11, 16'sh0002);
      send_request(OP_READ, 11, 11, '0);
      cover_window(11, 11, 1'b1, 16'sh7FFF);
      send_request(OP_READ, 11, 11, '0);
      cover_window(11, 11, 1'b1, 16'sh8000);
      send_request(OP_READ, 11, 11, 16'shFFFF);
   endtask

   task automatic test_grid_resize();
      send_request(OP_WRITE, 10, 0, 16'sh1234);
      configure(10, 20, 1);
      send_request(OP_WRITE, 10, 0, 16'sh4321);
      send_request(OP_WRITE, 0, 20, 16'sh5555);
      send_request(OP_READ, 200, 5, '0);
      cover_window(9, 19, 1'b0, '0);
      send_request(OP_READ, 9, 19, '0);
      configure(RESET_WIDTH, RESET_HEIGHT, RESET_RADIUS);
      cover_window(11, 1, 1'b0, '0);
      send_request(OP_READ, 11, 1, '0);
   endtask

   task automatic test_register_saturation();
      settle_block();
      write_register(CSR_GRID_WIDTH, '0);
      write_register(CSR_GRID_HEIGHT, '1);
      write_register(CSR_WINDOW_RADIUS, '0);
      write_register(CSR_UNUSED_INDEX, 9'h0AA);
      setting_count++;
      send_request(OP_READ, 0, 0, '0);
      send_request(OP_READ, 1, 0, '0);
      settle_block();
      write_register(CSR_WINDOW_RADIUS, 9'h1FF);
      write_register(CSR_UNUSED_INDEX, '0);
      setting_count++;
      cover_window(0, 3, 1'b0, '0);
      send_request(OP_READ, 0, 3, '0);
      cover_window(0, MAX_ROWS - 1, 1'b0, '0);
      send_request(OP_READ, 0, MAX_ROWS - 1, '0);
   endtask

   task automatic test_random_traffic();
      int widths [PHASE_COUNT];
      int heights [PHASE_COUNT];
      int radii [PHASE_COUNT];
      widths = '{256, 511, 1, 17, 256, 100, 0, 256};
      heights = '{256, 256, 1, 200, 5, 100, 300, 256};
      radii = '{8, 1, 8, 3, 5, 2, 4, 8};
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         configure(widths[phase], heights[phase], radii[phase]);
         if (phase == 0 || phase == PHASE_COUNT - 1) begin
            cover_window(130, 66, 1'b1, (phase == 0) ? 16'sh8000 : 16'sh7FFF);
            send_request(OP_READ, 130, 66, '0);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) random_item();
      end
   endtask

   initial begin
      grid_width_q = RESET_WIDTH;
      grid_height_q = RESET_HEIGHT;
      radius_q = RESET_RADIUS;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_power_on_defaults();
      test_mean_arithmetic();
      test_grid_resize();
      test_register_saturation();
      test_random_traffic();
      settle_block();
      $display("Covered %0d reads and %0d writes over %0d register settings,",
               read_count, write_count, setting_count);
      $display("%0d of them outside the grid; checked %0d responses with %0d failures.",
               range_count, checked_count, failure_count);
      if (failure_count == 0) begin
         $display("height_grid_box_blur_unit regression: pass");
      end else begin
         $display("height_grid_box_blur_unit regression: fail");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("height_grid_box_blur_unit regression: fail");
      $finish;
   end

endmodule
